### hdl/rvb_pkg.sv
// rvb_pkg: types, constants and microcode program of the stereo reverb core
// no dependencies; used by rvb_seq, rvb_dp and the top level
`default_nettype none

package rvb_pkg;

  typedef logic [4:0] wsel_t;

  // reverb word numbers in preset order
  localparam wsel_t W_DAPF1  = 5'd0;
  localparam wsel_t W_DAPF2  = 5'd1;
  localparam wsel_t W_VIIR   = 5'd2;
  localparam wsel_t W_VCOMB1 = 5'd3;
  localparam wsel_t W_VCOMB2 = 5'd4;
  localparam wsel_t W_VCOMB3 = 5'd5;
  localparam wsel_t W_VCOMB4 = 5'd6;
  localparam wsel_t W_VWALL  = 5'd7;
  localparam wsel_t W_VAPF1  = 5'd8;
  localparam wsel_t W_VAPF2  = 5'd9;
  localparam wsel_t W_MLSAME = 5'd10;
  localparam wsel_t W_MRSAME = 5'd11;
  localparam wsel_t W_MLCOMB1 = 5'd12;
  localparam wsel_t W_MRCOMB1 = 5'd13;
  localparam wsel_t W_MLCOMB2 = 5'd14;
  localparam wsel_t W_MRCOMB2 = 5'd15;
  localparam wsel_t W_DLSAME = 5'd16;
  localparam wsel_t W_DRSAME = 5'd17;
  localparam wsel_t W_MLDIFF = 5'd18;
  localparam wsel_t W_MRDIFF = 5'd19;
  localparam wsel_t W_MLCOMB3 = 5'd20;
  localparam wsel_t W_MRCOMB3 = 5'd21;
  localparam wsel_t W_MLCOMB4 = 5'd22;
  localparam wsel_t W_MRCOMB4 = 5'd23;
  localparam wsel_t W_DLDIFF = 5'd24;
  localparam wsel_t W_DRDIFF = 5'd25;
  localparam wsel_t W_MLAPF1 = 5'd26;
  localparam wsel_t W_MRAPF1 = 5'd27;
  localparam wsel_t W_MLAPF2 = 5'd28;
  localparam wsel_t W_MRAPF2 = 5'd29;
  localparam wsel_t W_VLIN   = 5'd30;
  localparam wsel_t W_VRIN   = 5'd31;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WORD   = 1'b1;

  typedef enum logic [3:0] {
    U_NOP, U_RD, U_LD, U_MULQ, U_MULR, U_MULA, U_PSET, U_PADD,
    U_PSUB, U_RADD, U_RSUB, U_RLD, U_QADD, U_SAT, U_WR, U_END
  } uop_op_t;

  typedef enum logic [1:0] {SB_NONE, SB_ONE, SB_D1, SB_D2} sub_t;

  typedef logic [2:0] rsel_t;
  localparam rsel_t R_XL = 3'd0;
  localparam rsel_t R_XR = 3'd1;
  localparam rsel_t R_PL = 3'd2;
  localparam rsel_t R_PR = 3'd3;
  localparam rsel_t R_SL = 3'd4;
  localparam rsel_t R_SR = 3'd5;
  localparam rsel_t R_OL = 3'd6;
  localparam rsel_t R_OR = 3'd7;

  typedef struct packed {
    uop_op_t op;
    wsel_t   w;
    sub_t    sub;
    rsel_t   r;
  } uop_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

  typedef logic [6:0] pc_t;
  localparam pc_t PC_END = 7'd124;

  function automatic uop_t mk(uop_op_t op, wsel_t w, sub_t sub, rsel_t r);
    uop_t u;
    u.op  = op;
    u.w   = w;
    u.sub = sub;
    u.r   = r;
    return u;
  endfunction

  // one reflection filter: s = sat(((x + d*wall - prev) * iir) + prev)
  function automatic uop_t f_refl(logic [3:0] k, rsel_t x, wsel_t m, wsel_t d,
                                  rsel_t s, rsel_t p);
    uop_t u;
    case (k)
      4'd0:  u = mk(U_RD,   m,       SB_ONE,  R_XL);
      4'd1:  u = mk(U_LD,   W_DAPF1, SB_NONE, p);
      4'd2:  u = mk(U_RD,   d,       SB_NONE, R_XL);
      4'd3:  u = mk(U_MULQ, W_VWALL, SB_NONE, R_XL);
      4'd4:  u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
      4'd5:  u = mk(U_RADD, W_DAPF1, SB_NONE, x);
      4'd6:  u = mk(U_RSUB, W_DAPF1, SB_NONE, p);
      4'd7:  u = mk(U_MULA, W_VIIR,  SB_NONE, R_XL);
      4'd8:  u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
      4'd9:  u = mk(U_RADD, W_DAPF1, SB_NONE, p);
      4'd10: u = mk(U_SAT,  W_DAPF1, SB_NONE, s);
      default: u = mk(U_NOP, W_DAPF1, SB_NONE, R_XL);
    endcase
    return u;
  endfunction

  // four comb taps summed into o
  function automatic uop_t f_comb(logic [3:0] k, wsel_t m1, wsel_t m2, wsel_t m3,
                                  wsel_t m4, rsel_t o);
    uop_t u;
    case (k)
      4'd0:  u = mk(U_RD,   m1,       SB_NONE, R_XL);
      4'd1:  u = mk(U_MULQ, W_VCOMB1, SB_NONE, R_XL);
      4'd2:  u = mk(U_PSET, W_DAPF1,  SB_NONE, R_XL);
      4'd3:  u = mk(U_RD,   m2,       SB_NONE, R_XL);
      4'd4:  u = mk(U_MULQ, W_VCOMB2, SB_NONE, R_XL);
      4'd5:  u = mk(U_PADD, W_DAPF1,  SB_NONE, R_XL);
      4'd6:  u = mk(U_RD,   m3,       SB_NONE, R_XL);
      4'd7:  u = mk(U_MULQ, W_VCOMB3, SB_NONE, R_XL);
      4'd8:  u = mk(U_PADD, W_DAPF1,  SB_NONE, R_XL);
      4'd9:  u = mk(U_RD,   m4,       SB_NONE, R_XL);
      4'd10: u = mk(U_MULQ, W_VCOMB4, SB_NONE, R_XL);
      4'd11: u = mk(U_PADD, W_DAPF1,  SB_NONE, R_XL);
      4'd12: u = mk(U_SAT,  W_DAPF1,  SB_NONE, o);
      default: u = mk(U_NOP, W_DAPF1, SB_NONE, R_XL);
    endcase
    return u;
  endfunction

  // one all-pass stage for both channels, o held in R_OL / R_OR
  function automatic uop_t f_ap(logic [4:0] k, wsel_t ml, wsel_t mr, sub_t sb,
                                wsel_t v);
    uop_t u;
    case (k)
      5'd0:  u = mk(U_RD,   ml,      sb,      R_XL);
      5'd1:  u = mk(U_MULQ, v,       SB_NONE, R_XL);
      5'd2:  u = mk(U_RLD,  W_DAPF1, SB_NONE, R_OL);
      5'd3:  u = mk(U_PSUB, W_DAPF1, SB_NONE, R_XL);
      5'd4:  u = mk(U_SAT,  W_DAPF1, SB_NONE, R_SL);
      5'd5:  u = mk(U_RD,   mr,      sb,      R_XL);
      5'd6:  u = mk(U_MULQ, v,       SB_NONE, R_XL);
      5'd7:  u = mk(U_RLD,  W_DAPF1, SB_NONE, R_OR);
      5'd8:  u = mk(U_PSUB, W_DAPF1, SB_NONE, R_XL);
      5'd9:  u = mk(U_SAT,  W_DAPF1, SB_NONE, R_SR);
      5'd10: u = mk(U_WR,   ml,      SB_NONE, R_SL);
      5'd11: u = mk(U_WR,   mr,      SB_NONE, R_SR);
      5'd12: u = mk(U_RD,   ml,      sb,      R_XL);
      5'd13: u = mk(U_MULR, v,       SB_NONE, R_SL);
      5'd14: u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
      5'd15: u = mk(U_QADD, W_DAPF1, SB_NONE, R_XL);
      5'd16: u = mk(U_SAT,  W_DAPF1, SB_NONE, R_OL);
      5'd17: u = mk(U_RD,   mr,      sb,      R_XL);
      5'd18: u = mk(U_MULR, v,       SB_NONE, R_SR);
      5'd19: u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
      5'd20: u = mk(U_QADD, W_DAPF1, SB_NONE, R_XL);
      5'd21: u = mk(U_SAT,  W_DAPF1, SB_NONE, R_OR);
      default: u = mk(U_NOP, W_DAPF1, SB_NONE, R_XL);
    endcase
    return u;
  endfunction

  // whole per-sample program
  function automatic uop_t prog(pc_t pc);
    uop_t u;
    if (pc < 7'd6) begin
      case (pc)
        7'd0: u = mk(U_MULR, W_VLIN,  SB_NONE, R_XL);
        7'd1: u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
        7'd2: u = mk(U_SAT,  W_DAPF1, SB_NONE, R_XL);
        7'd3: u = mk(U_MULR, W_VRIN,  SB_NONE, R_XR);
        7'd4: u = mk(U_PSET, W_DAPF1, SB_NONE, R_XL);
        default: u = mk(U_SAT, W_DAPF1, SB_NONE, R_XR);
      endcase
    end else if (pc < 7'd17) begin
      u = f_refl(4'(pc - 7'd6), R_XL, W_MLSAME, W_DLSAME, R_SL, R_PL);
    end else if (pc < 7'd28) begin
      u = f_refl(4'(pc - 7'd17), R_XR, W_MRSAME, W_DRSAME, R_SR, R_PR);
    end else if (pc == 7'd28) begin
      u = mk(U_WR, W_MLSAME, SB_NONE, R_SL);
    end else if (pc == 7'd29) begin
      u = mk(U_WR, W_MRSAME, SB_NONE, R_SR);
    end else if (pc < 7'd41) begin
      u = f_refl(4'(pc - 7'd30), R_XL, W_MLDIFF, W_DRDIFF, R_SL, R_PL);
    end else if (pc < 7'd52) begin
      u = f_refl(4'(pc - 7'd41), R_XR, W_MRDIFF, W_DLDIFF, R_SR, R_PR);
    end else if (pc == 7'd52) begin
      u = mk(U_WR, W_MLDIFF, SB_NONE, R_SL);
    end else if (pc == 7'd53) begin
      u = mk(U_WR, W_MRDIFF, SB_NONE, R_SR);
    end else if (pc < 7'd67) begin
      u = f_comb(4'(pc - 7'd54), W_MLCOMB1, W_MLCOMB2, W_MLCOMB3, W_MLCOMB4, R_OL);
    end else if (pc < 7'd80) begin
      u = f_comb(4'(pc - 7'd67), W_MRCOMB1, W_MRCOMB2, W_MRCOMB3, W_MRCOMB4, R_OR);
    end else if (pc < 7'd102) begin
      u = f_ap(5'(pc - 7'd80), W_MLAPF1, W_MRAPF1, SB_D1, W_VAPF1);
    end else if (pc < PC_END) begin
      u = f_ap(5'(pc - 7'd102), W_MLAPF2, W_MRAPF2, SB_D2, W_VAPF2);
    end else begin
      u = mk(U_END, W_DAPF1, SB_NONE, R_XL);
    end
    return u;
  endfunction

endpackage

`default_nettype wire

### hdl/rvb_ram.sv
// rvb_ram: generic single write port, single read port memory, registered read
// no dependencies
`default_nettype none

module rvb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/rvb_seq.sv
// rvb_seq: control state machine, program counter and memory clear counter
// depends on rvb_pkg
`default_nettype none

module rvb_seq #(
  parameter int ADDR_BITS = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_command,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rvb_pkg::uop_t             uop,
  output logic                      go,
  output logic                      cfg_we,
  output logic                      done,
  output logic                      clr_en,
  output logic [ADDR_BITS-1:0]      clr_addr
);
  import rvb_pkg::*;

  state_t                state_r, state_nxt;
  pc_t                   pc_r, pc_nxt;
  logic [ADDR_BITS-1:0]  clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pc_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    clr_nxt   = clr_r;
    uop       = mk(U_NOP, W_DAPF1, SB_NONE, R_XL);
    go        = 1'b0;
    cfg_we    = 1'b0;
    done      = 1'b0;
    clr_en    = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        clr_en  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == CMD_WORD) begin
            cfg_we = 1'b1;
          end else begin
            go        = 1'b1;
            pc_nxt    = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        uop = prog(pc_r);
        if (pc_r == PC_END) begin
          // hold the last step until the output register is free
          if (!out_valid_r || !out_stall) begin
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    out_valid_nxt = done | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;
  assign clr_addr  = clr_r;

endmodule

`default_nettype wire

### hdl/rvb_dp.sv
// rvb_dp: shared multiply/accumulate datapath, register file, reverb words,
// head pointer and delay memory; depends on rvb_pkg and rvb_ram
`default_nettype none

module rvb_dp #(
  parameter int ADDR_BITS   = 18,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rvb_pkg::uop_t         uop,
  input  wire logic                  go,
  input  wire logic                  cfg_we,
  input  wire logic                  done,
  input  wire logic                  clr_en,
  input  wire logic [ADDR_BITS-1:0]  clr_addr,
  input  wire logic signed [15:0]    in_left_in,
  input  wire logic signed [15:0]    in_right_in,
  input  wire logic [4:0]            in_reg_index,
  input  wire logic [15:0]           in_reg_value,
  output logic signed [15:0]         out_left_out,
  output logic signed [15:0]         out_right_out
);
  import rvb_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = SB + 3;
  localparam int PW  = AW + 16;
  localparam int SHL = (SB >= 16) ? SB - 16 : 0;
  localparam int SHR = (SB < 16) ? 16 - SB : 0;
  localparam logic signed [AW-1:0]    S_HI = AW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [AW-1:0]    S_LO = AW'(-(64'sd1 <<< (SB - 1)));
  localparam logic signed [SB+15:0]   O_HI = (SB + 16)'(32767);
  localparam logic signed [SB+15:0]   O_LO = (SB + 16)'(-32768);

  logic [15:0]           words_r [32];
  logic [ADDR_BITS-1:0]  head_r;
  logic [SB-1:0]         rf_r [8];
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [15:0]    left_r, right_r;

  logic [15:0]           wd;
  logic [19:0]           off_w, off_d1, off_d2;
  logic [ADDR_BITS-1:0]  base, sub_val, raddr, waddr;
  logic [SB-1:0]         ram_q, rf_q, sat_v;
  logic signed [AW-1:0]  ram_x, rf_x, opnd, pqa;
  logic signed [PW-1:0]  psh;
  logic signed [15:0]    gain_s;

  function automatic logic [SB-1:0] scale_in(input logic [15:0] v);
    logic signed [SB+15:0] e;
    logic signed [SB+15:0] s;
    e = {{SB{v[15]}}, v};
    s = (e <<< SHL) >>> SHR;
    return s[SB-1:0];
  endfunction

  function automatic logic [15:0] scale_out(input logic [SB-1:0] v);
    logic signed [SB+15:0] e;
    logic signed [SB+15:0] s;
    logic [15:0]           r;
    e = {{16{v[SB-1]}}, v};
    s = (e <<< SHR) >>> SHL;
    if (s > O_HI) begin
      r = 16'h7fff;
    end else if (s < O_LO) begin
      r = 16'h8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

  // word lookups: one selected word, two fixed all-pass delays
  assign wd     = words_r[uop.w];
  assign gain_s = $signed(wd);
  assign off_w  = {2'b00, wd, 2'b00};
  assign off_d1 = {2'b00, words_r[W_DAPF1], 2'b00};
  assign off_d2 = {2'b00, words_r[W_DAPF2], 2'b00};
  assign base   = off_w[ADDR_BITS-1:0];

  always_comb begin
    case (uop.sub)
      SB_NONE: sub_val = '0;
      SB_ONE:  sub_val = ADDR_BITS'(1);
      SB_D1:   sub_val = off_d1[ADDR_BITS-1:0];
      SB_D2:   sub_val = off_d2[ADDR_BITS-1:0];
      default: sub_val = '0;
    endcase
  end

  assign raddr = base + head_r - sub_val;
  assign waddr = clr_en ? clr_addr : base + head_r;

  rvb_ram #(
    .WIDTH (SB),
    .DEPTH (1 << ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (clr_en | (uop.op == U_WR)),
    .waddr (waddr),
    .wdata (clr_en ? '0 : rf_q),
    .re    (uop.op == U_RD),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign rf_q  = rf_r[uop.r];
  assign ram_x = {{3{ram_q[SB-1]}}, ram_q};
  assign rf_x  = {{3{rf_q[SB-1]}}, rf_q};

  always_comb begin
    case (uop.op)
      U_MULQ:  opnd = ram_x;
      U_MULR:  opnd = rf_x;
      default: opnd = acc_r;
    endcase
  end

  assign prod_nxt = opnd * gain_s;
  // gain product floors toward minus infinity
  assign psh      = prod_r >>> 15;
  assign pqa      = psh[AW-1:0];

  always_comb begin
    case (uop.op)
      U_PSET:  acc_nxt = pqa;
      U_PADD:  acc_nxt = acc_r + pqa;
      U_PSUB:  acc_nxt = acc_r - pqa;
      U_RADD:  acc_nxt = acc_r + rf_x;
      U_RSUB:  acc_nxt = acc_r - rf_x;
      U_RLD:   acc_nxt = rf_x;
      U_QADD:  acc_nxt = acc_r + ram_x;
      default: acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    if (acc_r > S_HI) begin
      sat_v = S_HI[SB-1:0];
    end else if (acc_r < S_LO) begin
      sat_v = S_LO[SB-1:0];
    end else begin
      sat_v = acc_r[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      for (int i = 0; i < 32; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        words_r[in_reg_index] <= in_reg_value;
      end
      if (done) begin
        head_r <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    // product holds until the next multiply step
    if (uop.op == U_MULQ || uop.op == U_MULR || uop.op == U_MULA) begin
      prod_r <= prod_nxt;
    end
    acc_r  <= acc_nxt;
    if (go) begin
      rf_r[R_XL] <= scale_in(in_left_in);
      rf_r[R_XR] <= scale_in(in_right_in);
    end else if (uop.op == U_LD) begin
      rf_r[uop.r] <= ram_q;
    end else if (uop.op == U_SAT) begin
      rf_r[uop.r] <= sat_v;
    end
    if (done) begin
      left_r  <= scale_out(rf_r[R_OL]);
      right_r <= scale_out(rf_r[R_OR]);
    end
  end

  assign out_left_out  = left_r;
  assign out_right_out = right_r;

endmodule

`default_nettype wire

### hdl/stereo_delay_line_reverb_core.sv
// stereo delay-line reverb: one stereo sample runs from accept to result word as
// 125 program steps on one shared multiply/accumulate unit and one delay memory
// port pair; one sample in flight, next word taken once it ends.
// a reverb word write gives no result.
// reset: synchronous, clears words and head pointer, then a clearing pass
// zeroes the delay memory while input stays stalled.
`default_nettype none

module stereo_delay_line_reverb_core #(
  parameter int ADDR_BITS   = 18,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic signed [15:0] in_left_in,
  input  wire logic signed [15:0] in_right_in,
  input  wire logic [4:0]         in_reg_index,
  input  wire logic [15:0]        in_reg_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left_out,
  output logic signed [15:0]      out_right_out
);
  import rvb_pkg::*;

  uop_t                  uop;
  logic                  go, cfg_we, done, clr_en;
  logic [ADDR_BITS-1:0]  clr_addr;

  rvb_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .uop        (uop),
    .go         (go),
    .cfg_we     (cfg_we),
    .done       (done),
    .clr_en     (clr_en),
    .clr_addr   (clr_addr)
  );

  rvb_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .uop           (uop),
    .go            (go),
    .cfg_we        (cfg_we),
    .done          (done),
    .clr_en        (clr_en),
    .clr_addr      (clr_addr),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .in_reg_index  (in_reg_index),
    .in_reg_value  (in_reg_value),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_SAMPLE |=> in_stall)
    else $error("sample accepted without entering busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(done))
    else $error("result word appeared without program end");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> uop.op == U_END && !clr_en)
    else $error("result taken outside the last program step");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

endmodule

`default_nettype wire
